/* design/vt4_pkg.sv */
// Shared types and constants for the 4x4 vertex transform.
// No dependencies; imported by every module of the block.
package vt4_pkg;

  localparam int unsigned NUM_LANES  = 4;
  localparam int unsigned COMP_W     = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned PROD_W     = COMP_W + COEF_W;
  localparam int unsigned PAIR_W     = PROD_W + 1;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned FRAC_SHIFT = 12;
  localparam int unsigned RND_W      = SUM_W - FRAC_SHIFT;
  localparam int unsigned ROW_W      = NUM_LANES * COEF_W;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned TDATA_W    = NUM_LANES * COMP_W + TAG_W;

  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_ADDR_W  = 5;
  localparam int unsigned ROW_SEL_LSB = 3;
  localparam int unsigned ROW_SEL_W   = CFG_ADDR_W - ROW_SEL_LSB;

  localparam logic signed [SUM_W-1:0]  ROUND_BIAS = SUM_W'(2048);
  localparam logic        [COMP_W-1:0] SAT_MAX    = 32'h7FFF_FFFF;
  localparam logic        [COMP_W-1:0] SAT_MIN    = 32'h8000_0000;

  typedef logic [ROW_W-1:0]               row_t;
  typedef logic [NUM_LANES-1:0][COMP_W-1:0] vertex_t;

  // Identity matrix at reset.
  localparam row_t ROW_RESET [NUM_LANES] = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_1000_0000,
    64'h0000_1000_0000_0000,
    64'h1000_0000_0000_0000
  };

  typedef struct packed {
    logic [COMP_W-1:0] value;
    logic              sat;
  } lane_res_t;

  typedef struct packed {
    logic              sat;
    logic [TAG_W-1:0]  tag;
    vertex_t           comp;
  } out_word_t;

endpackage

/* design/vt4_lane.sv */
// One row lane: four multiplies, two-level add with rounding bias,
// then floor shift and clamp to Q16.16. Depends on vt4_pkg.
module vt4_lane
  import vt4_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  vertex_t   vtx,
  input  row_t      row,
  output lane_res_t res
);

  logic signed [PROD_W-1:0] prod_r [NUM_LANES];
  logic signed [PAIR_W-1:0] pair_r [2];
  logic signed [SUM_W-1:0]  sum_r;

  logic [RND_W-1:0]           rnd;
  logic [RND_W-COMP_W:0]      hi;
  logic                       over;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        prod_r[k] <= $signed(row[COEF_W*k +: COEF_W]) * $signed(vtx[k]);
      end
      pair_r[0] <= PAIR_W'(prod_r[0]) + PAIR_W'(prod_r[1]);
      pair_r[1] <= PAIR_W'(prod_r[2]) + PAIR_W'(prod_r[3]);
      sum_r     <= SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]) + ROUND_BIAS;
    end
  end

  // Drop the fraction bits (floor), then clamp if the top bits disagree.
  always_comb begin
    rnd  = sum_r[SUM_W-1:FRAC_SHIFT];
    hi   = rnd[RND_W-1:COMP_W-1];
    over = !((&hi) || !(|hi));
    res.sat = over;
    if (over) begin
      res.value = rnd[RND_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      res.value = rnd[COMP_W-1:0];
    end
  end

endmodule

/* design/vt4_merge.sv */
// Merge stage: collect the lane results and the tag into one result word
// and hold it in a two-entry skid buffer. Depends on vt4_pkg.
module vt4_merge
  import vt4_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  lane_res_t          lane_res [NUM_LANES],
  input  logic [TAG_W-1:0]   tag,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic [0:0]         out_tuser
);

  out_word_t word;
  out_word_t main_r;
  out_word_t skid_r;
  logic      main_vld_r;
  logic      skid_vld_r;
  logic      push;
  logic      pop;

  always_comb begin
    word.sat = 1'b0;
    word.tag = tag;
    for (int k = 0; k < NUM_LANES; k++) begin
      word.comp[k] = lane_res[k].value;
      word.sat     = word.sat | lane_res[k].sat;
    end
  end

  assign up_ready = !skid_vld_r;
  assign push     = up_valid && up_ready;
  assign pop      = main_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_r <= word;
      end else begin
        skid_r <= word;
      end
    end
  end

  assign out_tvalid   = main_vld_r;
  assign out_tdata    = {main_r.tag, main_r.comp};
  assign out_tuser[0] = main_r.sat;

endmodule

/* design/vertex_transform_4x4.sv */
// Homogeneous vertex transform by a 4x4 Q4.12 matrix, Q16.16 in and out.
// Path: product, pair-sum and sum registers in the lanes, then the merge
// stage's main register. Throughput: one vertex per clock while the merge
// skid entry is empty, set by the multiply/add/add pipeline of the four row lanes and the skid buffer.
// Reset (rst_n low, synchronous): pipeline and output emptied, the matrix
// registers load the identity matrix.
module vertex_transform_4x4
  import vt4_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // in_x, in_y, in_z, in_w, in_tag
  // Result words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // out_x, out_y, out_z, out_w, out_tag
  output logic [0:0]            out_tuser,  // saturated
  // Configuration (row i at byte address 8*i)
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // Matrix rows, one register per row. The low address bits select a byte
  // within the row and are ignored, so every write lands on one of the rows.
  row_t                 row_r [NUM_LANES];
  logic [ROW_SEL_W-1:0] row_sel;
  logic                 cfg_wr;

  assign row_sel    = cfg_paddr[CFG_ADDR_W-1:ROW_SEL_LSB];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = row_r[row_sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        row_r[k] <= ROW_RESET[k];
      end
    end else if (cfg_wr) begin
      row_r[row_sel] <= cfg_pwdata;
    end
  end

  // Pipeline control. The whole pipe advances together; it holds only when
  // the merge stage has both of its entries full, so the input side never
  // waits on out_tready directly.
  logic             en;
  logic             s1_vld_r, s2_vld_r, s3_vld_r;
  logic [TAG_W-1:0] s1_tag_r, s2_tag_r, s3_tag_r;
  vertex_t          vtx;
  lane_res_t        lane_res [NUM_LANES];

  assign in_tready = en;
  assign vtx       = in_tdata[NUM_LANES*COMP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Tag travels alongside the lanes, untouched.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r <= in_tdata[TDATA_W-1:NUM_LANES*COMP_W];
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  // One lane per matrix row; each sees the whole vertex.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    vt4_lane u_lane (
      .clk (clk),
      .en  (en),
      .vtx (vtx),
      .row (row_r[g]),
      .res (lane_res[g])
    );
  end

  // Combine the lane results, OR the clamp flags, buffer the result word.
  vt4_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (s3_vld_r),
    .up_ready   (en),
    .lane_res   (lane_res),
    .tag        (s3_tag_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* design/vt4_checker.sv */
// Port-level checks for vertex_transform_4x4, attached by bind.
// Depends on vt4_pkg.
module vt4_checker
  import vt4_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [TDATA_W-1:0]    out_tdata,
  input logic [0:0]            out_tuser,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata,
  input logic                  cfg_pready
);

  // Hold a stalled result word.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // The input side stalls only when a result is waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // A row reads back what was just written to it.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) ##1
    (cfg_paddr[CFG_ADDR_W-1:ROW_SEL_LSB] == $past(cfg_paddr[CFG_ADDR_W-1:ROW_SEL_LSB]))
    |-> cfg_prdata == $past(cfg_pwdata))
    else $error("row register readback mismatch");

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (.*);

/* dv/tb.sv */
// Self-checking bench for vertex_transform_4x4: drives vertex words and
// matrix rows, then checks every result word against a directed table value or an in-bench model.
// Depends on vt4_pkg and the vertex_transform_4x4 RTL only.
module tb;
  import vt4_pkg::*;

  // Input word layout: x lowest, then y, z, w, tag.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    vertex_t          comp;
  } vertex_word_t;

  typedef enum int {MAT_UNIT, MAT_MAX, MAT_MIN, MAT_HALF, MAT_MIXED} mat_id_e;

  typedef struct {
    mat_id_e      mat;
    vertex_word_t word;
    bit           typed;
    out_word_t    want;
  } dir_row_t;

  localparam longint LANE_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint LANE_MIN   = -64'sh0000_0000_8000_0000;
  localparam int     PHASES     = 9;
  localparam int     PHASE_LEN  = 128;
  localparam int     DRAIN_WAIT = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata;    // in_x, in_y, in_z, in_w, in_tag
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;   // out_x, out_y, out_z, out_w, out_tag
  logic [0:0]            out_tuser;   // saturated
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Bench copy of the matrix; rows change only while the pipe is empty.
  row_t      coef_rows [NUM_LANES];
  out_word_t result_q [$];
  dir_row_t  dir_rows [$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        fails = 0;
  int        words_checked = 0;
  int        clamped_seen = 0;
  int        row_writes = 0;

  vertex_transform_4x4 dut (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Hard stop: a time limit for ~1200 words under heavy stalls, with a wide margin.
  initial begin
    #(12 * 600_000);
    $display("Regression FAIL");
    $finish;
  end

  // Row dot product per lane, Q20.28 rounded half up to Q16.16, clamped.
  function automatic out_word_t transform_vertex(vertex_word_t word);
    out_word_t         res;
    longint            acc;
    longint            rnd;
    logic signed [15:0] coef;
    logic signed [31:0] comp;
    res.sat = 1'b0;
    res.tag = word.tag;
    for (int i = 0; i < NUM_LANES; i++) begin
      acc = 0;
      for (int k = 0; k < NUM_LANES; k++) begin
        coef = coef_rows[i][COEF_W*k +: COEF_W];
        comp = word.comp[k];
        acc += longint'(coef) * longint'(comp);
      end
      rnd = (acc + 2048) >>> 12;
      if (rnd > LANE_MAX) begin
        res.comp[i] = SAT_MAX;
        res.sat     = 1'b1;
      end else if (rnd < LANE_MIN) begin
        res.comp[i] = SAT_MIN;
        res.sat     = 1'b1;
      end else begin
        res.comp[i] = rnd[31:0];
      end
    end
    return res;
  endfunction

  // Receiver: drop tready at random per the current stall rate.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check every accepted result word against the oldest pending one.
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_word_t'({out_tuser, out_tdata});
      if (result_q.size() == 0) begin
        $display("%0t: result word with none pending: %h", $time, got);
        fails++;
      end else begin
        want = result_q.pop_front();
        words_checked++;
        if (want.sat) clamped_seen++;
        for (int i = 0; i < NUM_LANES; i++) begin
          if (got.comp[i] !== want.comp[i]) begin
            $display("%0t: lane %0d mismatch: expected %h, got %h",
                     $time, i, want.comp[i], got.comp[i]);
            fails++;
          end
        end
        if (got.tag !== want.tag) begin
          $display("%0t: tag mismatch: expected %h, got %h", $time, want.tag, got.tag);
          fails++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: saturated mismatch: expected %b, got %b",
                   $time, want.sat, got.sat);
          fails++;
        end
      end
    end
  end

  // Present one vertex word, hold it until taken, queue its result.
  task automatic send_vertex(vertex_word_t word, out_word_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    result_q.push_back(want);
    @(negedge clk);
  endtask

  // Drop valid and wait for every pending result word to come back.
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Setup then access cycle; the row is taken at the access edge.
  task automatic cfg_write(int idx, row_t val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'(idx << ROW_SEL_LSB);
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    coef_rows[idx] = val;
    row_writes++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_check_row(int idx);
    row_t got;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'(idx << ROW_SEL_LSB);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    if (got !== coef_rows[idx]) begin
      $display("%0t: row %0d readback: expected %h, got %h",
               $time, idx, coef_rows[idx], got);
      fails++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write all four rows, then read each back.
  task automatic load_matrix(row_t rows [NUM_LANES]);
    for (int i = 0; i < NUM_LANES; i++) cfg_write(i, rows[i]);
    for (int i = 0; i < NUM_LANES; i++) cfg_check_row(i);
  endtask

  task automatic add_row(mat_id_e m, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                         logic [31:0] w, logic [31:0] tag, bit typed,
                         logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                         logic [31:0] ew, logic esat);
    dir_row_t r;
    r.mat            = m;
    r.word.comp      = {w, z, y, x};
    r.word.tag       = tag;
    r.typed          = typed;
    r.want.comp      = {ew, ez, ey, ex};
    r.want.tag       = tag;
    r.want.sat       = esat;
    dir_rows.push_back(r);
  endtask

  initial begin : stimulus
    row_t         rows [NUM_LANES];
    mat_id_e      cur_mat;
    vertex_word_t word;
    out_word_t    want;
    logic [15:0]  coef;
    int           phase_mode;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    coef_rows   = ROW_RESET;

    // Identity after reset: every word comes back unchanged, no clamping.
    add_row(MAT_UNIT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1,
            32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    add_row(MAT_UNIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'hFFFF_FFFF, 1,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_row(MAT_UNIT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h0, 1,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_row(MAT_UNIT, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
            32'h1234_5678, 1,
            32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
    add_row(MAT_UNIT, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
            32'hA5A5_A5A5, 1,
            32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    // Largest positive coefficients: full-scale inputs clamp every lane.
    add_row(MAT_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h5A5A_5A5A, 1,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add_row(MAT_MAX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h0F0F_0F0F, 1,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    add_row(MAT_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 32'hF0F0_F0F0, 1,
            32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    add_row(MAT_MAX, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h1, 0,
            32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    add_row(MAT_MAX, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0000_8000, 32'h2, 0,
            32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    // Most negative coefficients: sign flips on the clamp.
    add_row(MAT_MIN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h3, 1,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add_row(MAT_MIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h4, 1,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    add_row(MAT_MIN, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h5, 0,
            32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    // Half-scale diagonal: odd inputs land on ties, which round up.
    add_row(MAT_HALF, 32'h1, 32'hFFFF_FFFF, 32'h3, 32'hFFFF_FFFD, 32'h6, 1,
            32'h1, 32'h0, 32'h2, 32'hFFFF_FFFF, 1'b0);
    add_row(MAT_HALF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7, 1,
            32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 1'b0);
    add_row(MAT_HALF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8, 1,
            32'hC000_0000, 32'hC000_0000, 32'hC000_0000, 32'hC000_0000, 1'b0);
    add_row(MAT_HALF, 32'h5, 32'hFFFF_FFFB, 32'h7, 32'h0, 32'h9, 0,
            32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    // Clamp on some lanes only: x row scales by ~8, w row by -8.
    add_row(MAT_MIXED, 32'h7FFF_FFFF, 32'h0000_1234, 32'hFFFF_EDCC, 32'h7FFF_FFFF,
            32'hA, 1,
            32'h7FFF_FFFF, 32'h0000_1234, 32'hFFFF_EDCC, 32'h8000_0000, 1'b1);
    add_row(MAT_MIXED, 32'h7FFF_FFFF, 32'h0000_0042, 32'h0, 32'h0, 32'hB, 1,
            32'h7FFF_FFFF, 32'h0000_0042, 32'h0, 32'h0, 1'b1);
    add_row(MAT_MIXED, 32'h0000_1000, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_0800,
            32'hC, 0,
            32'h0, 32'h0, 32'h0, 32'h0, 1'b0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    // Reset values must read back as the identity matrix.
    for (int i = 0; i < NUM_LANES; i++) cfg_check_row(i);

    // Walk the directed table; reload the matrix whenever a row asks for another.
    cur_mat = MAT_UNIT;
    foreach (dir_rows[n]) begin
      if (dir_rows[n].mat != cur_mat) begin
        drain_pipe();
        for (int i = 0; i < NUM_LANES; i++) begin
          case (dir_rows[n].mat)
            MAT_MAX:  rows[i] = 64'h7FFF_7FFF_7FFF_7FFF;
            MAT_MIN:  rows[i] = 64'h8000_8000_8000_8000;
            MAT_HALF: rows[i] = ROW_RESET[i] >> 1;
            MAT_MIXED: begin
              rows[i] = ROW_RESET[i];
              if (i == 0) rows[i] = 64'h0000_0000_0000_7FFF;
              if (i == NUM_LANES - 1) rows[i] = 64'h8000_0000_0000_0000;
            end
            default:  rows[i] = ROW_RESET[i];
          endcase
        end
        load_matrix(rows);
        cur_mat = dir_rows[n].mat;
      end
      want = dir_rows[n].typed ? dir_rows[n].want : transform_vertex(dir_rows[n].word);
      send_vertex(dir_rows[n].word, want);
    end

    // Random phases: new matrix each phase, pacing mode advances every third.
    for (int p = 0; p < PHASES; p++) begin
      drain_pipe();
      for (int i = 0; i < NUM_LANES; i++) begin
        for (int k = 0; k < NUM_LANES; k++) begin
          case ($urandom_range(5))
            0:       coef = 16'($urandom);
            1:       coef = '0;
            2:       coef = 16'h7FFF;
            3:       coef = 16'h8000;
            default: coef = 16'($urandom_range(32'h2800) - 32'h1400);
          endcase
          rows[i][COEF_W*k +: COEF_W] = coef;
        end
      end
      load_matrix(rows);
      phase_mode = p / 3;
      send_idle_pct = (phase_mode == 0) ? 14 : (phase_mode == 1) ? 78 : 0;
      recv_idle_pct = (phase_mode == 0) ? 78 : (phase_mode == 1) ? 14 : 0;
      for (int n = 0; n < PHASE_LEN; n++) begin
        // Half in-range magnitudes so lanes stay unclamped; the rest random or full scale.
        for (int k = 0; k < NUM_LANES; k++) begin
          case ($urandom_range(7))
            0, 1:    word.comp[k] = $urandom;
            2:       word.comp[k] = 32'h7FFF_FFFF;
            3:       word.comp[k] = 32'h8000_0000;
            default: word.comp[k] = $urandom_range(32'h0200_0000) - 32'h0100_0000;
          endcase
        end
        word.tag = $urandom;
        send_vertex(word, transform_vertex(word));
      end
    end

    drain_pipe();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (result_q.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, result_q.size());
      fails++;
    end

    $display("Checked %0d vertex words (%0d clamped) across %0d row writes,",
             words_checked, clamped_seen, row_writes);
    $display("under three pacing modes: slow sender, slow receiver, full rate.");
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
